// File: sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // fixed geometry
  localparam int unsigned PAGES_PER_REGION = 64;
  localparam logic [5:0] LAST_SLOT = 6'(PAGES_PER_REGION - 1);
  localparam logic [9:0] BIOS_REGIONS = 10'd8;
  localparam logic [15:0] END_LINK = 16'hffff;
  localparam logic [16:0] COUNT_MAX = 17'h1ffff;
  localparam logic [15:0] RESERVED_RESET = 16'd512;
  localparam logic [15:0] HEAD_RESET = 16'd512;
  localparam logic [15:0] BIOS_END_PAGE = 16'd511;

  // actions
  localparam logic [1:0] ACT_ALLOC_PAGE = 2'd0;
  localparam logic [1:0] ACT_FREE_PAGE = 2'd1;
  localparam logic [1:0] ACT_ALLOC_REGION = 2'd2;
  localparam logic [1:0] ACT_FREE_REGION = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // register index
  localparam logic REG_RESERVED = 1'b0;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PG_CHK,
    S_PA_UPD,
    S_PF_UPD,
    S_FR_CHK,
    S_FR_LOAD,
    S_FR_LOOP,
    S_SC_RD,
    S_SC_CHK,
    S_W1_CHK,
    S_W1_NXT,
    S_W2_CHK,
    S_W2_NXT,
    S_DONE
  } state_t;

  // page checks from the shared compare unit
  typedef struct packed {
    logic below_res;
    logic in_pages;
    logic same_region;
    logic has_map;
  } chk_t;

endpackage

`default_nettype wire

// File: sv/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/pfa_unit.sv
// ----------------------------------------------------------------------------
// pfa_unit
// Shared page compare unit: range, reservation, region match and bit mask.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_unit #(
  parameter int PAGE_COUNT = 65518,
  parameter int REGION_COUNT = 1024
) (
  input  wire logic [15:0] page,
  input  wire logic [9:0]  region,
  input  wire logic [15:0] reserved,
  output pfa_pkg::chk_t    chk,
  output logic [63:0]      mask
);

  localparam logic [16:0] PC17 = 17'(PAGE_COUNT);
  localparam logic [10:0] RC11 = 11'(REGION_COUNT);

  // compares on the page number
  always_comb begin
    chk.below_res   = page < reserved;
    chk.in_pages    = {1'b0, page} < PC17;
    chk.same_region = page[15:6] == region;
    chk.has_map     = {1'b0, page[15:6]} < RC11;
    mask            = 64'd1 << page[5:0];
  end

endmodule

`default_nettype wire

// File: sv/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_allocator
// Free list page frame allocator with per-region occupancy bitmaps.
// ----------------------------------------------------------------------------
// Usage: a request (action, target) is taken on req_valid & req_ready; one
// response (result_index, status, free_pages) leaves on rsp_valid & rsp_ready.
// The user must write reserved_pages over the APB port only while the block
// is idle; the block itself does not enforce this. After reset the block
// sweeps both tables, one entry a cycle, over max(PAGE_COUNT, REGION_COUNT)
// entries (65518 by default); req_ready stays low meanwhile, APB writes are
// taken as usual. One request at a time runs through a small sequencer
// sharing one compare unit and two single-read-port tables:
//   allocate/free page: check, then table update, then the done state posts
//   the response; a rejected page goes straight to the done state
//   free region: check, bitmap load, one page per cycle up to the last slot,
//   with an early stop on a rejected page
//   allocate region: scan bitmap words, walk list links, post the response
// The response register decouples the sides: a new request is accepted while
// a response waits; a stalled receiver holds the next result in the
// sequencer until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator #(
  parameter int PAGE_COUNT = 65518,
  parameter int REGION_COUNT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] target,
  // response channel
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [15:0]      result_index,
  output logic [1:0]       status,
  output logic [15:0]      free_pages,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LAW = $clog2(PAGE_COUNT);
  localparam int RAW = $clog2(REGION_COUNT);
  localparam int SWEEP = (PAGE_COUNT > REGION_COUNT) ? PAGE_COUNT : REGION_COUNT;
  localparam logic [15:0] SWEEP_LAST = 16'(SWEEP - 1);
  localparam logic [15:0] PC16 = 16'(PAGE_COUNT);
  localparam logic [15:0] PC_LAST = 16'(PAGE_COUNT - 1);
  localparam logic [15:0] RC16 = 16'(REGION_COUNT);
  localparam logic [10:0] RC11 = 11'(REGION_COUNT);
  localparam logic [15:0] SCAN_LAST = 16'(REGION_COUNT - 1);
  localparam logic [RAW-1:0] CUR_LAST = RAW'(REGION_COUNT - 1);
  localparam logic [15:0] FULL_REG = 16'(PAGE_COUNT / 64);
  localparam int TAIL = PAGE_COUNT % 64;
  localparam logic [63:0] TAIL_MASK = ~64'd0 << TAIL;
  localparam logic [16:0] PPR17 = 17'(pfa_pkg::PAGES_PER_REGION);

  pfa_pkg::state_t state, state_next;

  logic [1:0]     act;
  logic [15:0]    pg;
  logic [15:0]    prev;
  logic           have_prev;
  logic [9:0]     rg;
  logic [15:0]    cnt;
  logic [63:0]    word;
  logic [15:0]    head;
  logic [16:0]    count;
  logic [RAW-1:0] cursor;
  logic [15:0]    reserved;
  logic [15:0]    res_idx;
  logic [1:0]     res_st;

  // table ports
  logic           lk_we;
  logic [LAW-1:0] lk_waddr, lk_raddr;
  logic [15:0]    lk_wdata, lk_rdata;
  logic           bm_we;
  logic [RAW-1:0] bm_waddr, bm_raddr;
  logic [63:0]    bm_wdata, bm_rdata;

  // shared compare unit
  logic [15:0]    u_page;
  pfa_pkg::chk_t  chk;
  logic [63:0]    mask;

  logic page_ok, w2_more, rg_bad, last_slot, out_free;
  logic [63:0] init_word;
  logic [15:0] init_link;

  assign u_page = (state == pfa_pkg::S_FR_LOOP) ? {rg, cnt[5:0]} : pg;

  pfa_unit #(
    .PAGE_COUNT  (PAGE_COUNT),
    .REGION_COUNT(REGION_COUNT)
  ) u_unit (
    .page    (u_page),
    .region  (rg),
    .reserved(reserved),
    .chk     (chk),
    .mask    (mask)
  );

  pfa_ram #(.DEPTH(PAGE_COUNT), .WIDTH(16)) u_link (
    .clk  (clk),
    .we   (lk_we),
    .waddr(lk_waddr),
    .wdata(lk_wdata),
    .raddr(lk_raddr),
    .rdata(lk_rdata)
  );

  pfa_ram #(.DEPTH(REGION_COUNT), .WIDTH(64)) u_map (
    .clk  (clk),
    .we   (bm_we),
    .waddr(bm_waddr),
    .wdata(bm_wdata),
    .raddr(bm_raddr),
    .rdata(bm_rdata)
  );

  // common conditions
  assign page_ok   = !chk.below_res && chk.in_pages;
  assign w2_more   = chk.in_pages && chk.same_region && (cnt != PC16);
  assign rg_bad    = (rg < pfa_pkg::BIOS_REGIONS) || ({1'b0, rg} >= RC11);
  assign last_slot = cnt[5:0] == pfa_pkg::LAST_SLOT;
  assign out_free  = !rsp_valid || rsp_ready;

  // reset contents of the tables
  always_comb begin
    if (cnt < 16'(pfa_pkg::BIOS_REGIONS)) begin
      init_word = ~64'd0;
    end else if (cnt < FULL_REG) begin
      init_word = 64'd0;
    end else if (cnt == FULL_REG) begin
      init_word = TAIL_MASK;
    end else begin
      init_word = ~64'd0;
    end
    if ((cnt == pfa_pkg::BIOS_END_PAGE) || (cnt == PC_LAST)) begin
      init_link = pfa_pkg::END_LINK;
    end else begin
      init_link = cnt + 16'd1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfa_pkg::S_INIT: begin
        if (cnt == SWEEP_LAST) state_next = pfa_pkg::S_IDLE;
      end
      pfa_pkg::S_IDLE: begin
        if (req_valid) begin
          unique case (action)
            pfa_pkg::ACT_ALLOC_PAGE,
            pfa_pkg::ACT_FREE_PAGE:    state_next = pfa_pkg::S_PG_CHK;
            pfa_pkg::ACT_ALLOC_REGION: state_next = pfa_pkg::S_SC_RD;
            default:                   state_next = pfa_pkg::S_FR_CHK;
          endcase
        end
      end
      pfa_pkg::S_PG_CHK: begin
        if (!page_ok) begin
          state_next = pfa_pkg::S_DONE;
        end else if (act == pfa_pkg::ACT_ALLOC_PAGE) begin
          state_next = pfa_pkg::S_PA_UPD;
        end else begin
          state_next = pfa_pkg::S_PF_UPD;
        end
      end
      pfa_pkg::S_PA_UPD: state_next = pfa_pkg::S_DONE;
      pfa_pkg::S_PF_UPD: state_next = pfa_pkg::S_DONE;
      pfa_pkg::S_FR_CHK: begin
        state_next = rg_bad ? pfa_pkg::S_DONE : pfa_pkg::S_FR_LOAD;
      end
      pfa_pkg::S_FR_LOAD: state_next = pfa_pkg::S_FR_LOOP;
      pfa_pkg::S_FR_LOOP: begin
        if (!page_ok || last_slot) state_next = pfa_pkg::S_DONE;
      end
      pfa_pkg::S_SC_RD: state_next = pfa_pkg::S_SC_CHK;
      pfa_pkg::S_SC_CHK: begin
        if (bm_rdata == 64'd0) begin
          state_next = pfa_pkg::S_W1_CHK;
        end else if (cnt == SCAN_LAST) begin
          state_next = pfa_pkg::S_DONE;
        end else begin
          state_next = pfa_pkg::S_SC_RD;
        end
      end
      pfa_pkg::S_W1_CHK: begin
        if (!chk.in_pages) begin
          state_next = pfa_pkg::S_DONE;
        end else if (chk.same_region) begin
          state_next = pfa_pkg::S_W2_CHK;
        end else if (cnt == PC16) begin
          state_next = pfa_pkg::S_DONE;
        end else begin
          state_next = pfa_pkg::S_W1_NXT;
        end
      end
      pfa_pkg::S_W1_NXT: state_next = pfa_pkg::S_W1_CHK;
      pfa_pkg::S_W2_CHK: begin
        state_next = w2_more ? pfa_pkg::S_W2_NXT : pfa_pkg::S_DONE;
      end
      pfa_pkg::S_W2_NXT: state_next = pfa_pkg::S_W2_CHK;
      pfa_pkg::S_DONE: begin
        if (out_free) state_next = pfa_pkg::S_IDLE;
      end
      default: state_next = pfa_pkg::S_INIT;
    endcase
  end

  // table controls
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = pg[LAW-1:0];
    lk_wdata = head;
    lk_raddr = pg[LAW-1:0];
    bm_we    = 1'b0;
    bm_waddr = rg[RAW-1:0];
    bm_wdata = word;
    bm_raddr = pg[RAW+5:6];
    req_ready = 1'b0;
    unique case (state)
      pfa_pkg::S_INIT: begin
        lk_we    = cnt < PC16;
        lk_waddr = cnt[LAW-1:0];
        lk_wdata = init_link;
        bm_we    = cnt < RC16;
        bm_waddr = cnt[RAW-1:0];
        bm_wdata = init_word;
      end
      pfa_pkg::S_IDLE: req_ready = 1'b1;
      pfa_pkg::S_PG_CHK: begin
        lk_we = (act == pfa_pkg::ACT_FREE_PAGE) && page_ok;
      end
      pfa_pkg::S_PA_UPD: begin
        bm_we    = chk.has_map;
        bm_waddr = pg[RAW+5:6];
        bm_wdata = bm_rdata | mask;
      end
      pfa_pkg::S_PF_UPD: begin
        bm_we    = chk.has_map;
        bm_waddr = pg[RAW+5:6];
        bm_wdata = bm_rdata & ~mask;
      end
      pfa_pkg::S_FR_CHK: bm_raddr = rg[RAW-1:0];
      pfa_pkg::S_FR_LOOP: begin
        lk_we    = page_ok;
        lk_waddr = u_page[LAW-1:0];
        bm_we    = !page_ok || last_slot;
        bm_wdata = page_ok ? (word & ~mask) : word;
      end
      pfa_pkg::S_SC_RD: bm_raddr = cursor;
      pfa_pkg::S_W2_CHK: begin
        lk_we    = !w2_more && have_prev;
        lk_waddr = prev[LAW-1:0];
        lk_wdata = pg;
        bm_we    = !w2_more;
        bm_wdata = ~64'd0;
      end
      default: begin
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfa_pkg::S_INIT;
      cnt       <= 16'd0;
      head      <= pfa_pkg::HEAD_RESET;
      count     <= 17'(PAGE_COUNT);
      cursor    <= '0;
      have_prev <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // response taken; a new one is posted only from the done state
      if (rsp_valid && rsp_ready && (state != pfa_pkg::S_DONE)) rsp_valid <= 1'b0;
      unique case (state)
        pfa_pkg::S_INIT: cnt <= cnt + 16'd1;
        pfa_pkg::S_IDLE: begin
          act       <= action;
          pg        <= (action == pfa_pkg::ACT_ALLOC_PAGE) ? head : target;
          rg        <= target[9:0];
          cnt       <= 16'd0;
          have_prev <= 1'b0;
          res_idx   <= 16'd0;
          res_st    <= pfa_pkg::ST_OK;
        end
        pfa_pkg::S_PG_CHK: begin
          if (!page_ok) begin
            res_st <= (act == pfa_pkg::ACT_ALLOC_PAGE) ? pfa_pkg::ST_NOMEM : pfa_pkg::ST_BAD;
          end else if (act == pfa_pkg::ACT_FREE_PAGE) begin
            head  <= pg;
            count <= (count == pfa_pkg::COUNT_MAX) ? count : count + 17'd1;
          end
        end
        pfa_pkg::S_PA_UPD: begin
          head    <= lk_rdata;
          count   <= (count > 17'd1) ? count - 17'd1 : 17'd0;
          res_idx <= pg;
        end
        pfa_pkg::S_FR_CHK: begin
          if (rg_bad) res_st <= pfa_pkg::ST_BAD;
        end
        pfa_pkg::S_FR_LOAD: word <= bm_rdata;
        pfa_pkg::S_FR_LOOP: begin
          if (page_ok) begin
            head  <= u_page;
            count <= (count == pfa_pkg::COUNT_MAX) ? count : count + 17'd1;
            word  <= word & ~mask;
            cnt   <= cnt + 16'd1;
          end else begin
            res_st <= pfa_pkg::ST_BAD;
          end
        end
        pfa_pkg::S_SC_CHK: begin
          if (bm_rdata == 64'd0) begin
            rg  <= 10'(cursor);
            pg  <= head;
            cnt <= 16'd0;
          end else begin
            cursor <= (cursor == CUR_LAST) ? '0 : cursor + 1'b1;
            cnt    <= cnt + 16'd1;
            if (cnt == SCAN_LAST) res_st <= pfa_pkg::ST_NOMEM;
          end
        end
        pfa_pkg::S_W1_CHK: begin
          if (!chk.in_pages || (!chk.same_region && cnt == PC16)) begin
            res_st <= pfa_pkg::ST_BAD;
          end else if (chk.same_region) begin
            cnt <= 16'd0;
          end else begin
            prev      <= pg;
            have_prev <= 1'b1;
            cnt       <= cnt + 16'd1;
          end
        end
        pfa_pkg::S_W1_NXT: pg <= lk_rdata;
        pfa_pkg::S_W2_CHK: begin
          if (w2_more) begin
            cnt <= cnt + 16'd1;
          end else begin
            if (!have_prev) head <= pg;
            count   <= (count > PPR17) ? count - PPR17 : 17'd0;
            res_idx <= {6'd0, rg};
          end
        end
        pfa_pkg::S_W2_NXT: pg <= lk_rdata;
        pfa_pkg::S_DONE: begin
          if (out_free) begin
            rsp_valid    <= 1'b1;
            result_index <= res_idx;
            status       <= res_st;
            free_pages   <= (count > 17'h0ffff) ? 16'hffff : count[15:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= pfa_pkg::RESERVED_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == pfa_pkg::REG_RESERVED)) begin
      reserved <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pfa_pkg::REG_RESERVED) ? {16'd0, reserved} : 32'd0;

endmodule

`default_nettype wire
